@@ hdl/a85_pkg.sv @@
// a85_pkg: constants, types and helpers for the ASCII85 decoder.
// No dependencies; imported by the decoder core.
`default_nettype none

package a85_pkg;

  localparam logic [7:0] DIGIT_LO = 8'h21;   // '!'
  localparam logic [7:0] DIGIT_HI = 8'h75;   // 'u'
  localparam logic [7:0] CH_Z     = 8'h7a;   // 'z'
  localparam logic [7:0] CH_TILDE = 8'h7e;   // '~'
  localparam logic [7:0] CH_GT    = 8'h3e;   // '>'

  localparam int GV_W    = 26;  // value of up to four digits, below 85^4
  localparam int ACC_W   = 33;  // five digits, below 85^5
  localparam int SCALE_W = 20;  // largest pad scale 85^3
  localparam int CNT_W   = 3;
  localparam logic [CNT_W-1:0] GROUP_FULL = 3'd4;

  // Work handed from the state update stage to the output stage.
  typedef struct packed {
    logic [31:0]      word;   // full group or 'z' word
    logic [CNT_W-1:0] nres;   // bytes from word, 0 or 4
    logic             flush;  // partial group to pad at end of stream
    logic [GV_W-1:0]  fgv;
    logic [CNT_W-1:0] fcnt;
    logic             last;
  } work_t;

  // 85^(5-n): padding with digit 84 gives v*scale + scale - 1.
  function automatic logic [SCALE_W-1:0] pad_scale(input logic [CNT_W-1:0] n);
    logic [SCALE_W-1:0] s;
    case (n)
      3'd2:    s = 20'd614125;
      3'd3:    s = 20'd7225;
      3'd4:    s = 20'd85;
      default: s = 20'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/a85_in_if.sv @@
// a85_in_if: encoded character channel, valid/ready handshake.
// No dependencies.
`default_nettype none

interface a85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       stream_last;

  modport source (output valid, output char_in, output stream_last, input ready);
  modport sink   (input valid, input char_in, input stream_last, output ready);
endinterface

`default_nettype wire

@@ hdl/a85_out_if.sv @@
// a85_out_if: decoded byte channel, valid/ready handshake.
// No dependencies.
`default_nettype none

interface a85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output byte_out, output byte_valid, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input run_last,
                  input stream_end, output ready);
endinterface

`default_nettype wire

@@ hdl/ascii85_decoder_core.sv @@
// ASCII85 stream decoder: one character word in, decoded byte words out.
// Depends on a85_pkg, a85_in_if and a85_out_if.
//
// Usage:
//   in_ch carries one encoded character per word, stream_last marking the
//   final character. out_ch carries decoded bytes; run_last flags the last
//   byte caused by one character, stream_end the last byte of a stream. A
//   stream whose end yields no byte still gives one word with byte_valid 0.
// Path: a character is registered, then updates the group state, then
//   the padded tail multiply feeds the output buffer, which presents its
//   first byte on out_ch.
// Throughput: one character per cycle unless the output buffer stalls. A full
//   group, 'z' or an end flush drains one byte per cycle from the output buffer
//   while out_ch is ready, so a burst of four bytes holds the three-stage pipe.
// Reset (rst, synchronous): empties all stages and clears the group state.
// Receiver stall: the output buffer holds its word; the stages behind it
//   keep filling, then in_ch.ready drops until the buffer moves again.
`default_nettype none

module ascii85_decoder_core
  import a85_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  a85_in_if.sink    in_ch,
  a85_out_if.source out_ch
);

  // input register
  logic             a_valid;
  logic [7:0]       a_char;
  logic             a_last;
  // decoding state
  logic [GV_W-1:0]  gv, gv_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             tp, tp_next;
  logic             term, term_next;
  // work register
  logic             b_valid;
  work_t            b, b_next;
  // output buffer
  logic             o_valid;
  logic [31:0]      o_word;
  logic [CNT_W-1:0] o_rem;
  logic             o_blank;
  logic             o_end;

  logic a_adv, b_adv, b_has_out, o_pop, o_load_ok;

  // ---- handshake ----
  assign o_pop     = o_valid && out_ch.ready;
  assign o_load_ok = !o_valid || (o_pop && o_rem == 3'd1);
  assign b_has_out = b.last || b.nres != '0;
  assign b_adv     = b_valid && (!b_has_out || o_load_ok);
  assign a_adv     = a_valid && (!b_valid || b_adv);
  assign in_ch.ready = !a_valid || a_adv;

  // ---- state update ----
  logic [ACC_W-1:0] gv_ext, acc;
  logic [6:0]       digit;
  logic             is_digit;

  always_comb begin
    gv_ext   = {{(ACC_W-GV_W){1'b0}}, gv};
    digit    = 7'(a_char - DIGIT_LO);
    is_digit = a_char inside {[DIGIT_LO:DIGIT_HI]};
    // gv*85 + digit, 85 = 64+16+4+1
    acc = (gv_ext << 6) + (gv_ext << 4) + (gv_ext << 2) + gv_ext
        + {{(ACC_W-7){1'b0}}, digit};

    gv_next   = gv;
    cnt_next  = cnt;
    tp_next   = tp;
    term_next = term;
    b_next    = '0;

    if (!term) begin
      tp_next = 1'b0;
      if (tp && a_char == CH_GT) begin
        term_next = 1'b1;
      end else if (is_digit) begin
        if (cnt == GROUP_FULL) begin
          b_next.word = acc[31:0];
          b_next.nres = 3'd4;
          gv_next     = '0;
          cnt_next    = '0;
        end else begin
          gv_next  = acc[GV_W-1:0];
          cnt_next = cnt + 3'd1;
        end
      end else if (a_char == CH_Z) begin
        b_next.nres = 3'd4;
        gv_next     = '0;
        cnt_next    = '0;
      end else if (a_char == CH_TILDE) begin
        if (a_last) begin
          term_next = 1'b1;
        end else begin
          tp_next = 1'b1;
        end
      end
    end

    if (a_last) begin
      b_next.last = 1'b1;
      if (cnt_next >= 3'd2) begin
        b_next.flush = 1'b1;
        b_next.fgv   = gv_next;
        b_next.fcnt  = cnt_next;
      end
      gv_next   = '0;
      cnt_next  = '0;
      tp_next   = 1'b0;
      term_next = 1'b0;
    end
  end

  // ---- tail padding and buffer load ----
  logic [SCALE_W-1:0]      scale;
  logic [GV_W+SCALE_W-1:0] prod;
  logic [31:0]             pad_word, load_word;
  logic [CNT_W-1:0]        load_n;

  always_comb begin
    scale    = pad_scale(b.fcnt);
    prod     = b.fgv * scale;
    pad_word = prod[31:0] + {{(32-SCALE_W){1'b0}}, scale} - 32'd1;
    if (b.flush) begin
      load_word = pad_word;
      load_n    = b.fcnt - 3'd1;
    end else begin
      load_word = b.word;
      load_n    = b.nres;
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      gv      <= '0;
      cnt     <= '0;
      tp      <= 1'b0;
      term    <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
      o_rem   <= '0;
      o_blank <= 1'b0;
      o_end   <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        a_valid <= in_ch.valid;
      end
      if (a_adv) begin
        gv   <= gv_next;
        cnt  <= cnt_next;
        tp   <= tp_next;
        term <= term_next;
      end
      if (!b_valid || b_adv) begin
        b_valid <= a_adv;
      end
      if (b_adv && b_has_out) begin
        o_valid <= 1'b1;
        o_end   <= b.last;
        if (load_n == '0) begin
          o_rem   <= 3'd1;
          o_blank <= 1'b1;
        end else begin
          o_rem   <= load_n;
          o_blank <= 1'b0;
        end
      end else if (o_pop) begin
        o_rem <= o_rem - 3'd1;
        if (o_rem == 3'd1) begin
          o_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      a_char <= in_ch.char_in;
      a_last <= in_ch.stream_last;
    end
    if (a_adv) begin
      b <= b_next;
    end
    if (b_adv && b_has_out) begin
      o_word <= (load_n == '0) ? 32'd0 : load_word;
    end else if (o_pop) begin
      o_word <= o_word << 8;
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.byte_out   = o_word[31:24];
  assign out_ch.byte_valid = !o_blank;
  assign out_ch.run_last   = o_rem == 3'd1;
  assign out_ch.stream_end = o_end && o_rem == 3'd1;

endmodule

`default_nettype wire

@@ hdl/a85_checker.sv @@
// a85_checker: port-level assertions for the ASCII85 decoder core.
// Bound to ascii85_decoder_core; no other dependencies.
`default_nettype none

module a85_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] byte_out,
  input wire logic       byte_valid,
  input wire logic       run_last,
  input wire logic       stream_end
);

  // end of stream always closes the current run
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    valid && stream_end |-> run_last)
    else $error("stream_end without run_last");

  // an empty word only marks the end of a stream, and carries zero
  a_blank_is_end: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_valid |-> stream_end && byte_out == 8'd0)
    else $error("empty word outside stream end");

  // nothing leaves straight after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !valid)
    else $error("output valid right after reset");

  // stalled word holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    $past(valid && !ready) && !$past(rst) |-> valid && $stable(byte_out)
      && $stable(byte_valid) && $stable(run_last) && $stable(stream_end))
    else $error("stalled output word changed");

endmodule

bind ascii85_decoder_core a85_checker u_a85_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (out_ch.valid),
  .ready      (out_ch.ready),
  .byte_out   (out_ch.byte_out),
  .byte_valid (out_ch.byte_valid),
  .run_last   (out_ch.run_last),
  .stream_end (out_ch.stream_end)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for ascii85_decoder_core: drives character streams with random gaps and stalls,
// predicts the decoded byte words and checks every output word against that prediction.
// Depends on a85_pkg, a85_in_if, a85_out_if and the decoder core.

module testbench
  import a85_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 500;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } byte_word_t;

  logic clk;
  logic rst;

  a85_in_if  in_ch ();
  a85_out_if out_ch ();

  ascii85_decoder_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_item_t pending_chars[$];
  byte_word_t expected_bytes[$];

  // Decoder state as the predictor tracks it
  logic [32:0] acc_value;
  logic [2:0]  acc_digits;
  logic        tilde_seen;
  logic        end_seen;

  int cycle_count;
  int chars_accepted;
  int total_chars;
  int words_checked;
  int streams_built;
  int error_count;
  int tx_gap;
  int rx_gap;
  int hold_left;
  bit hold_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones; every gap drawn while cycle_count bits 9:8 are both set is zero.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (cycle_count[9:8] == 2'b11 || r < 6)
      return 0;
    else if (r < 9)
      return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 7) == 0)
      return DIGIT_HI;
    return 8'($urandom_range(DIGIT_LO, DIGIT_HI));
  endfunction

  function automatic logic [7:0] rand_filler();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h0a;
      2:       return 8'h00;
      3:       return 8'hff;
      4:       return 8'($urandom_range(8'h76, 8'h79));  // just above the digit range
      default: return 8'($urandom_range(8'h80, 8'hff));
    endcase
  endfunction

  task automatic predict_char(input logic [7:0] ch, input logic last);
    byte_word_t  res[$];
    byte_word_t  w;
    logic        was_tilde;
    logic [63:0] pad;
    logic [31:0] grp;
    int          k;
    w = '0;
    if (!end_seen) begin
      was_tilde  = tilde_seen;
      tilde_seen = 1'b0;
      if (was_tilde && ch == CH_GT) begin
        end_seen = 1'b1;
      end else if (ch >= DIGIT_LO && ch <= DIGIT_HI) begin
        pad        = 64'(acc_value) * 85 + 64'(ch - DIGIT_LO);
        acc_value  = pad[32:0];
        acc_digits = acc_digits + 3'd1;
        if (acc_digits >= 3'd5) begin
          grp = acc_value[31:0];
          for (k = 0; k < 4; k++) begin
            w.byte_out   = grp[31 - 8*k -: 8];
            w.byte_valid = 1'b1;
            res.push_back(w);
          end
          acc_value  = '0;
          acc_digits = '0;
        end
      end else if (ch == CH_Z) begin
        acc_value  = '0;
        acc_digits = '0;
        w.byte_out   = 8'h00;
        w.byte_valid = 1'b1;
        repeat (4) res.push_back(w);
      end else if (ch == CH_TILDE) begin
        if (last)
          end_seen = 1'b1;
        else
          tilde_seen = 1'b1;
      end
    end
    if (last) begin
      if (acc_digits >= 3'd2 && acc_digits <= 3'd4) begin
        pad = 64'(acc_value);
        for (k = int'(acc_digits); k < 5; k++)
          pad = pad * 85 + 64'd84;
        grp = pad[31:0];
        for (k = 0; k < int'(acc_digits) - 1; k++) begin
          w.byte_out   = grp[31 - 8*k -: 8];
          w.byte_valid = 1'b1;
          res.push_back(w);
        end
      end
      if (res.size() == 0) begin
        w = '0;
        res.push_back(w);
      end
      res[res.size() - 1].stream_end = 1'b1;
      acc_value  = '0;
      acc_digits = '0;
      tilde_seen = 1'b0;
      end_seen   = 1'b0;
    end
    if (res.size() > 0)
      res[res.size() - 1].run_last = 1'b1;
    foreach (res[k])
      expected_bytes.push_back(res[k]);
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    pending_chars.push_back('{ch: ch, last: last});
  endtask

  task automatic push_str(input string t, input logic last);
    int i;
    for (i = 0; i < t.len(); i++)
      push_char(t[i], last && (i == t.len() - 1));
  endtask

  // Mostly well-formed streams with random content; the rest noise or broken sequences.
  task automatic add_stream();
    logic [7:0] s[$];
    int         j;
    int         n;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) begin
          s.push_back(CH_Z);
        end else begin
          for (j = 0; j < 5; j++) begin
            s.push_back(rand_digit());
            if ($urandom_range(0, 9) == 0)
              s.push_back(rand_filler());
          end
        end
      end
      n = $urandom_range(0, 4);
      repeat (n) s.push_back(rand_digit());
      if ($urandom_range(0, 7) == 0)
        s.insert($urandom_range(0, s.size()), CH_TILDE);
      case ($urandom_range(0, 3))
        0, 1: begin
          s.push_back(CH_TILDE);
          s.push_back(CH_GT);
          n = $urandom_range(0, 3);
          repeat (n) s.push_back(8'($urandom_range(0, 255)));
        end
        2: begin
          s.push_back(CH_TILDE);
        end
        default: ;
      endcase
    end
    if (s.size() == 0)
      s.push_back(rand_filler());
    for (j = 0; j < s.size(); j++)
      push_char(s[j], j == s.size() - 1);
    streams_built++;
  endtask

  // Driver: presents queued characters, idles between words at random
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.char_in     <= 8'h00;
      in_ch.stream_last <= 1'b0;
      tx_gap            <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_char(in_ch.char_in, in_ch.stream_last);
        chars_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          in_ch.valid       <= 1'b1;
          in_ch.char_in     <= pending_chars[0].ch;
          in_ch.stream_last <= pending_chars[0].last;
          void'(pending_chars.pop_front());
          tx_gap            <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off once the random part is under way
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_accepted >= 100) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each decoded word against the oldest prediction
  always @(posedge clk) begin
    byte_word_t exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("decoded word with no prediction waiting: byte_out %0h", out_ch.byte_out);
          error_count++;
        end else begin
          exp_w = expected_bytes.pop_front();
          words_checked++;
          if (out_ch.byte_out !== exp_w.byte_out) begin
            $error("byte_out: expected %0h, got %0h", exp_w.byte_out, out_ch.byte_out);
            error_count++;
          end
          if (out_ch.byte_valid !== exp_w.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", exp_w.byte_valid, out_ch.byte_valid);
            error_count++;
          end
          if (out_ch.run_last !== exp_w.run_last) begin
            $error("run_last: expected %0b, got %0b", exp_w.run_last, out_ch.run_last);
            error_count++;
          end
          if (out_ch.stream_end !== exp_w.stream_end) begin
            $error("stream_end: expected %0b, got %0b", exp_w.stream_end, out_ch.stream_end);
            error_count++;
          end
        end
        if (rx_gap == 0)
          rx_gap <= pick_gap();
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
      end
      out_ch.ready <= (hold_left == 0) && (rx_gap == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    acc_value  = '0;
    acc_digits = '0;
    tilde_seen = 1'b0;
    end_seen   = 1'b0;

    // Directed: partial group dropped by 'z', all-ones and overflowing groups,
    // lone tilde and '>' as a digit, skipped bytes, end mark then ignored bytes
    // with a two-digit flush on the last one
    push_str("!!z", 1'b0);
    push_str("s8W-!", 1'b0);
    push_str("uuuuu", 1'b0);
    push_str("~a>", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b0);
    push_char(8'h20, 1'b0);
    push_str("~>x", 1'b0);
    push_char(8'h80, 1'b1);
    // tilde as the final byte, single leftover digit, oversized padded tail
    push_str("~", 1'b1);
    push_str("!v", 1'b1);
    push_str("uuuu", 1'b1);
    streams_built = 4;

    while (pending_chars.size() < RANDOM_CHARS + 30)
      add_stream();
    total_chars = pending_chars.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every prediction is queued by the time the last character is taken
    while (chars_accepted < total_chars)
      @(posedge clk);
    while (expected_bytes.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      $error("%0d predicted words never arrived", expected_bytes.size());
      error_count++;
    end
    $display("Decoded %0d characters in %0d streams, %0d output words checked",
             chars_accepted, streams_built, words_checked);
    $display("Covered full groups, 'z', end marks, stray tildes, noise and tail flushes");
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
